[src/slist_pkg.sv]
// Shared types, codes and controller/datapath interface structs for the sorted list unit.
`timescale 1ns / 1ps

package slist_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic               func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_STEP,
    S_INS_CHK,
    S_REM_RD,
    S_REM_CHK,
    S_SHF_RD,
    S_SHF_WR,
    S_REF_LO,
    S_REF_HI,
    S_REF_CAP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_ZERO,
    RD_LAST
  } rd_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_DEC,
    IDX_INC
  } idx_op_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    logic       wr_rdata;
    idx_op_t    idx_op;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_status;
    logic [1:0] status_code;
    logic       cap_lo;
    logic       cap_hi;
    logic       clr_minmax;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic full;
    logic cnt_zero;
    logic idx_zero;
    logic idx_eq_cnt;
    logic idx_p1_eq_cnt;
    logic rd_lt;
    logic rd_eq;
    logic out_busy;
  } stat_t;

endpackage

[src/slist_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module slist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/slist_ctrl.sv]
// Controller state machine that sequences insert, remove and min/max refresh steps.
`timescale 1ns / 1ps

module slist_ctrl import slist_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_IDX;
    cmd.idx_op = IDX_HOLD;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.func == FUNC_REMOVE) begin
          state_nxt = S_REM_RD;
        end else if (stat.full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_FULL;
          state_nxt       = S_DONE;
        end else begin
          state_nxt = S_INS_STEP;
        end
      end
      S_INS_STEP: begin
        if (stat.idx_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_REF_LO;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_nxt  = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_lt) begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_REF_LO;
        end else begin
          // Entry below is not smaller: move it up one place and keep walking down.
          cmd.wr_rdata = 1'b1;
          cmd.idx_op   = IDX_DEC;
          state_nxt    = S_INS_STEP;
        end
      end
      S_REM_RD: begin
        if (stat.idx_eq_cnt) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOMATCH;
          state_nxt       = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt  = S_REM_CHK;
        end
      end
      S_REM_CHK: begin
        if (stat.rd_eq) begin
          state_nxt = S_SHF_RD;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_REM_RD;
        end
      end
      S_SHF_RD: begin
        if (stat.idx_p1_eq_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_REF_LO;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
          state_nxt  = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.idx_op   = IDX_INC;
        state_nxt    = S_SHF_RD;
      end
      S_REF_LO: begin
        if (stat.cnt_zero) begin
          cmd.clr_minmax = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ZERO;
          state_nxt  = S_REF_HI;
        end
      end
      S_REF_HI: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_nxt  = S_REF_CAP;
      end
      S_REF_CAP: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item still in work");
  a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !stat.out_busy) |=> (state_r == S_IDLE))
    else $error("result not handed to output register");
`endif

endmodule

[src/slist_dpath.sv]
// Datapath: entry RAM, walk index, count, min/max and output register.
`timescale 1ns / 1ps

module slist_dpath import slist_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_stall,
  input  cmd_t      cmd,
  output stat_t     stat
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic               func_r;
  logic signed [31:0] v_r;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]         status_r;
  logic signed [31:0] lo_r, hi_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [CW-1:0]      idx_m1, idx_p1, cnt_m1;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;
  logic [31:0]        wdata;
  logic [CW+4:0]      cnt_ext;

  assign idx_m1 = idx_r - CW'(1);
  assign idx_p1 = idx_r + CW'(1);
  assign cnt_m1 = cnt_r - CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    raddr = idx_r[AW-1:0];
      RD_IDX_M1: raddr = idx_m1[AW-1:0];
      RD_IDX_P1: raddr = idx_p1[AW-1:0];
      RD_ZERO:   raddr = '0;
      RD_LAST:   raddr = cnt_m1[AW-1:0];
      default:   raddr = '0;
    endcase
  end

  assign wdata = cmd.wr_rdata ? rdata : v_r;

  slist_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (idx_r[AW-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = (in_data.func == FUNC_REMOVE) ? '0 : cnt_r;
    end else begin
      case (cmd.idx_op)
        IDX_DEC: idx_nxt = idx_m1;
        IDX_INC: idx_nxt = idx_p1;
        default: idx_nxt = idx_r;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cnt_ext = {5'd0, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_data.func;
      v_r      <= in_data.value;
      status_r <= ST_DONE;
    end else if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '0;
    end else if (cmd.clr_minmax) begin
      lo_r <= '0;
      hi_r <= '0;
    end else begin
      if (cmd.cap_lo) lo_r <= $signed(rdata);
      if (cmd.cap_hi) hi_r <= $signed(rdata);
    end
    if (cmd.out_load) begin
      out_data_r.status      <= status_r;
      out_data_r.entry_count <= cnt_ext[4:0];
      out_data_r.smallest    <= lo_r;
      out_data_r.largest     <= hi_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.func          = func_r;
  assign stat.full          = (cnt_r == CW'(CAPACITY));
  assign stat.cnt_zero      = (cnt_r == '0);
  assign stat.idx_zero      = (idx_r == '0);
  assign stat.idx_eq_cnt    = (idx_r == cnt_r);
  assign stat.idx_p1_eq_cnt = (idx_p1 == cnt_r);
  assign stat.rd_lt         = ($signed(rdata) < v_r);
  assign stat.rd_eq         = ($signed(rdata) == v_r);
  assign stat.out_busy      = out_valid_r && out_stall;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= cnt_r)
    else $error("walk index beyond held entries");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");
`endif

endmodule

[src/sorted_list_insert_remove_unit.sv]
// Top level of the sorted list unit: a bounded ascending multiset of signed words.
`timescale 1ns / 1ps

// The unit keeps up to CAPACITY signed 32-bit values in ascending order in a RAM.
// Input channel (in_valid, in_stall, in_data): a transfer carries func and value.
// func selects insert (placed before the first entry that is not smaller) or remove
// (deletes one equal entry). Every input transfer yields exactly one result on the
// output channel (out_valid, out_stall, out_data): a status code, the number of
// held entries and the smallest and largest entries (zero when the store is empty).
// An insert into a full store is dropped with status full; a remove that finds no
// equal entry leaves the store alone and reports no match.
// The RAM has one read port and one write port. An insert walks down from the top,
// reading each entry below and writing it up one place until a smaller one is met,
// then writes the value; a remove compares entries from the bottom up to the match,
// then shifts each entry above it down by a read and a write.
// A change ends with a min/max reread of both end entries; a dropped insert or a
// failed remove skips it. The unit takes one item at a time: in_stall is low only
// while it waits for work. A finished result sits in an output register, so a new
// item is taken while the receiver stalls; only the next result waits for room.
// Reset (rst_n low, synchronous) empties the store, zeroes the min/max and clears
// the output valid; no clearing pass is needed because only entries below the
// count are ever read.

module sorted_list_insert_remove_unit import slist_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Command and status buses between the sequencer and the datapath.
  cmd_t  cmd;
  stat_t stat;

  // The controller owns the input handshake and decides every RAM access.
  slist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the entries, the count, the min/max and the result register.
  slist_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
